// File: src/multi_mode_software_timer_top_macros.svh
// Assertion helpers for the timer block.
`ifndef MULTI_MODE_SOFTWARE_TIMER_TOP_MACROS_SVH
`define MULTI_MODE_SOFTWARE_TIMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMST_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("timer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMST_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("timer check failed");

`endif

// File: src/mmst_pkg.sv
`timescale 1ns / 1ps
package mmst_pkg;

    // Default counter width
    localparam int COUNT_WIDTH_DEF = 32;

    // Field widths fixed by the interface
    localparam int OPCODE_W   = 3;
    localparam int FIELD_W    = 32;
    localparam int REMAIN_W   = 64;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // Input tdata layout
    localparam int RUN_EN_BIT       = 0;
    localparam int LOAD_COUNT_LSB   = 1;
    localparam int LOAD_REPEATS_LSB = 33;

    // Output tdata layout
    localparam int RUNNING_BIT = 0;
    localparam int EXPIRED_BIT = 1;
    localparam int REMAIN_LSB  = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_RUN = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 3'd4;

    // Timer modes; any other code runs as repeat mode
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPEAT   = 2'd2;

    // Remaining-time status codes
    localparam logic [STATUS_W-1:0] STAT_VALID   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IDLE    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ENDLESS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELOAD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [FIELD_W-1:0] RELOAD_RESET = 32'd100;

    // Timer flags after an item
    typedef struct packed {
        logic running;
        logic expired;
    } mmst_flags_t;

endpackage

// File: src/mmst_ctrl.sv
`timescale 1ns / 1ps
module mmst_ctrl #(
    parameter int COUNT_WIDTH = mmst_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [mmst_pkg::OPCODE_W-1:0] opcode,
    input  logic                          run_enable,
    input  logic [COUNT_WIDTH-1:0]        load_count,
    input  logic [COUNT_WIDTH-1:0]        load_repeats,
    input  logic [mmst_pkg::MODE_W-1:0]   timer_mode,
    input  logic [COUNT_WIDTH-1:0]        reload_cnt,
    input  logic [COUNT_WIDTH-1:0]        repeat_cnt,
    output mmst_pkg::mmst_flags_t         flags_next,
    output logic [COUNT_WIDTH-1:0]        tick_next,
    output logic [COUNT_WIDTH-1:0]        repeats_next
);
    import mmst_pkg::*;

    logic [COUNT_WIDTH-1:0] tick_reg;
    logic [COUNT_WIDTH-1:0] repeats_reg;
    logic                   run_reg;
    logic                   expired_reg;
    logic                   run_next;
    logic                   expired_next;
    logic [COUNT_WIDTH-1:0] tick_dec;
    logic [COUNT_WIDTH-1:0] repeats_dec;
    logic [COUNT_WIDTH-1:0] reload_m1;
    logic                   tick_nz;
    logic                   tick_last;
    logic                   repeats_nz;

    assign tick_dec    = tick_reg - COUNT_WIDTH'(1);
    assign repeats_dec = repeats_reg - COUNT_WIDTH'(1);
    assign reload_m1   = reload_cnt - COUNT_WIDTH'(1);
    assign tick_nz     = (tick_reg != '0);
    assign tick_last   = (tick_reg == COUNT_WIDTH'(1));
    assign repeats_nz  = (repeats_reg != '0);

    // Apply one item to the timer state
    always_comb
    begin
        tick_next    = tick_reg;
        repeats_next = repeats_reg;
        run_next     = run_reg;
        expired_next = expired_reg;
        unique case (opcode)
            OP_TICK:
            begin
                if (run_reg)
                begin
                    unique case (timer_mode)
                        MODE_ONESHOT:
                        begin
                            if (tick_nz)
                            begin
                                tick_next = tick_dec;
                                if (tick_last)
                                begin
                                    expired_next = 1'b1;
                                    run_next     = 1'b0;
                                end
                            end
                        end
                        MODE_PERIODIC:
                        begin
                            if (tick_last)
                            begin
                                expired_next = 1'b1;
                                tick_next    = reload_cnt;
                            end
                            else if (tick_nz)
                            begin
                                tick_next = tick_dec;
                            end
                            else
                            begin
                                tick_next = reload_m1;
                            end
                        end
                        default:
                        begin
                            // Repeat mode; the spare mode code behaves the same
                            if (tick_nz)
                            begin
                                tick_next = tick_dec;
                                if (tick_last)
                                begin
                                    expired_next = 1'b1;
                                    if (repeats_nz)
                                    begin
                                        repeats_next = repeats_dec;
                                        tick_next    = reload_cnt;
                                    end
                                    else
                                    begin
                                        run_next = 1'b0;
                                    end
                                end
                            end
                            else if (repeats_nz)
                            begin
                                repeats_next = repeats_dec;
                                tick_next    = reload_m1;
                            end
                            else
                            begin
                                run_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            OP_RESTART:
            begin
                run_next     = 1'b0;
                expired_next = 1'b0;
                tick_next    = reload_cnt;
                if (timer_mode != MODE_PERIODIC && timer_mode != MODE_ONESHOT)
                begin
                    repeats_next = repeat_cnt;
                end
            end
            OP_SET_RUN:
            begin
                run_next = run_enable;
            end
            OP_LOAD:
            begin
                tick_next    = load_count;
                repeats_next = load_repeats;
            end
            default:
            begin
                // Query and unused codes leave the state alone
            end
        endcase
    end

    assign flags_next.running = run_next;
    assign flags_next.expired = expired_next;

    // Commit the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            repeats_reg <= '0;
            run_reg     <= 1'b0;
            expired_reg <= 1'b0;
        end
        else if (accept)
        begin
            tick_reg    <= tick_next;
            repeats_reg <= repeats_next;
            run_reg     <= run_next;
            expired_reg <= expired_next;
        end
    end

endmodule

// File: src/multi_mode_software_timer_top.sv
`timescale 1ns / 1ps
// A result reaches the master side through the snapshot register and then the output register.
// Throughput: one item per cycle unless m_axis_tready stalls; the state update for an item
// finishes in its accept cycle; the remaining-time multiply and add feed the output register.
// Reset: rst_n clears the timer to stopped, not expired, zero counts, and loads the
// registers with mode periodic, reload 100 and repeat count 0; no item is in flight.
module multi_mode_software_timer_top #(
    parameter int COUNT_WIDTH = mmst_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // run_enable [0], load_count [32:1], load_repeats [64:33], zero fill [71:65]
    input  logic [mmst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode [2:0]
    input  logic [mmst_pkg::OPCODE_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // running [0], expired [1], remaining [65:2], zero fill [71:66]
    output logic [mmst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // remaining_status [1:0]
    output logic [mmst_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [mmst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mmst_pkg::FIELD_W-1:0]     cfg_wdata
);
    import mmst_pkg::*;

    logic [MODE_W-1:0]        mode_reg;
    logic [FIELD_W-1:0]       reload_reg;
    logic [FIELD_W-1:0]       repeat_reg;
    logic                     accept;
    logic                     out_adv;
    mmst_flags_t              flags_next;
    logic [COUNT_WIDTH-1:0]   tick_next;
    logic [COUNT_WIDTH-1:0]   repeats_next;
    logic                     snap_valid_reg;
    mmst_flags_t              snap_flags_reg;
    logic [COUNT_WIDTH-1:0]   snap_tick_reg;
    logic [COUNT_WIDTH-1:0]   snap_repeats_reg;
    logic [2*COUNT_WIDTH-1:0] product;
    logic [REMAIN_W-1:0]      remain_next;
    logic [STATUS_W-1:0]      status_next;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic [STATUS_W-1:0]      out_user_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PERIODIC;
            reload_reg <= RELOAD_RESET;
            repeat_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODE:   mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_RELOAD: reload_reg <= cfg_wdata;
                REG_REPEAT: repeat_reg <= cfg_wdata;
                default:
                begin
                    // Unmapped index: drop the write
                end
            endcase
        end
    end

    // Handshake: the snapshot stage frees up when the output register moves
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !snap_valid_reg || out_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mmst_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (s_axis_tuser),
        .run_enable   (s_axis_tdata[RUN_EN_BIT]),
        .load_count   (s_axis_tdata[LOAD_COUNT_LSB +: COUNT_WIDTH]),
        .load_repeats (s_axis_tdata[LOAD_REPEATS_LSB +: COUNT_WIDTH]),
        .timer_mode   (mode_reg),
        .reload_cnt   (reload_reg[COUNT_WIDTH-1:0]),
        .repeat_cnt   (repeat_reg[COUNT_WIDTH-1:0]),
        .flags_next   (flags_next),
        .tick_next    (tick_next),
        .repeats_next (repeats_next)
    );

    // Snapshot valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            snap_valid_reg <= s_axis_tvalid;
        end
    end

    // Capture the post-item state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snap_flags_reg   <= flags_next;
            snap_tick_reg    <= tick_next;
            snap_repeats_reg <= repeats_next;
        end
    end

    // Remaining time and status from the snapshot
    assign product = (2*COUNT_WIDTH)'(snap_repeats_reg)
                   * (2*COUNT_WIDTH)'(reload_reg[COUNT_WIDTH-1:0]);

    always_comb
    begin
        remain_next = '0;
        status_next = STAT_IDLE;
        if (snap_flags_reg.running)
        begin
            unique case (mode_reg)
                MODE_PERIODIC:
                begin
                    remain_next = REMAIN_W'(snap_tick_reg);
                    status_next = STAT_ENDLESS;
                end
                MODE_ONESHOT:
                begin
                    remain_next = REMAIN_W'(snap_tick_reg);
                    status_next = STAT_VALID;
                end
                default:
                begin
                    remain_next = REMAIN_W'(product) + REMAIN_W'(snap_tick_reg);
                    status_next = STAT_VALID;
                end
            endcase
        end
        else if (snap_flags_reg.expired)
        begin
            status_next = STAT_VALID;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_adv && snap_valid_reg)
        begin
            out_data_reg <= OUT_DATA_W'({remain_next, snap_flags_reg.expired,
                                         snap_flags_reg.running});
            out_user_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// File: src/mmst_checker.sv
`timescale 1ns / 1ps
`include "multi_mode_software_timer_top_macros.svh"
module mmst_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mmst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [mmst_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import mmst_pkg::*;

    logic                running;
    logic                expired;
    logic [REMAIN_W-1:0] remaining;
    logic                in_seen;

    assign running   = m_axis_tdata[RUNNING_BIT];
    assign expired   = m_axis_tdata[EXPIRED_BIT];
    assign remaining = m_axis_tdata[REMAIN_LSB +: REMAIN_W];
    assign in_seen   = s_axis_tvalid && s_axis_tready;

    // Hold a stalled item
    `MMST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A stopped, never expired timer reports nothing left
    `MMST_ASSERT_NOW(a_idle_report, clk, rst_n, m_axis_tvalid && !running && !expired,
        m_axis_tuser == STAT_IDLE && remaining == '0)

    // A stopped, expired timer reports a valid zero
    `MMST_ASSERT_NOW(a_expired_report, clk, rst_n, m_axis_tvalid && !running && expired,
        m_axis_tuser == STAT_VALID && remaining == '0)

    // A running timer never reports the idle status
    `MMST_ASSERT_NOW(a_running_status, clk, rst_n, m_axis_tvalid && running,
        m_axis_tuser == STAT_VALID || m_axis_tuser == STAT_ENDLESS)

    // Each accepted item is followed, past the snapshot register, by a valid output register
    `MMST_ASSERT_NEXT(a_accept_flows, clk, rst_n, in_seen, ##1 m_axis_tvalid)

endmodule

bind multi_mode_software_timer_top mmst_checker u_mmst_checker (.*);
